// File: design/binc_pkg.sv
package binc_pkg;

    // Line store depth and row limit defaults
    localparam int BINC_MAX_WIDTH  = 1024;
    localparam int BINC_MAX_HEIGHT = 1024;

    // Configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_MAX   = (1 << CFG_W) - 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_DIAGONALS = 2'd2;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH     = 11'd1024;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT    = 11'd1024;
    localparam logic             RST_COUNT_DIAGONALS = 1'b1;

    // Stream payload
    localparam int STREAM_W = 8;
    localparam int COUNT_W  = 4;

    // Line store entry: bit 1 upper row, bit 0 middle row
    localparam int LINE_W = 2;

endpackage

// File: design/binary_image_neighbor_counter.sv
// Pipeline: the input beat that completes a window is registered in stage 1, then in the
//   output register; in item terms results trail the input by image_width + 1 beats.
// Throughput: one input beat per cycle unless the output stalls, set by one line store
//   read at accept and one write back as it leaves stage 1, forwarded on a repeat column.
// Reset: rst_n clears counters, window, pipeline valids and configuration (1024, 1024, 1).
//   The line store is not cleared; rows above the image are masked by the row counter.
module binary_image_neighbor_counter
    import binc_pkg::*;
#(
    parameter int MAX_WIDTH  = BINC_MAX_WIDTH,
    parameter int MAX_HEIGHT = BINC_MAX_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // Pixel stream in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [STREAM_W-1:0]  s_tdata,   // [0] pixel, [7:1] zero
    input  logic                 s_tuser,   // [0] func: 0 pixel, 1 drain
    // Result stream out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [STREAM_W-1:0]  m_tdata,   // [3:0] neighbor_count, [4] empty_pixel, [7:5] zero
    output logic                 m_tlast    // [0] last_pixel
);

    // Address of the line store and effective dimension ranges
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int W_HI = (MAX_WIDTH < CFG_MAX) ? MAX_WIDTH : CFG_MAX;
    localparam int H_HI = (MAX_HEIGHT < CFG_MAX) ? MAX_HEIGHT : CFG_MAX;
    localparam int WW   = $clog2(W_HI + 1);
    localparam int HW   = $clog2(H_HI + 1);
    // Row counter runs up to two past the last row (the row of the final drain beat)
    localparam int RW   = $clog2(H_HI + 2);
    // Common width for column compares
    localparam int CW   = ((AW + 1) > WW) ? (AW + 1) : WW;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             diag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            height_reg <= RST_IMAGE_HEIGHT;
            diag_reg   <= RST_COUNT_DIAGONALS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:     width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT:    height_reg <= cfg_data;
                REG_COUNT_DIAGONALS: diag_reg   <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // Clamp dimensions to 1 .. limit
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WW'(1);
        else if (width_reg > CFG_W'(W_HI))
            w_eff = WW'(W_HI);
        else
            w_eff = WW'(width_reg);

        if (height_reg == '0)
            h_eff = HW'(1);
        else if (height_reg > CFG_W'(H_HI))
            h_eff = HW'(H_HI);
        else
            h_eff = HW'(height_reg);
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic s1_go;
    logic s_accept;

    // Output register is free or being drained this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign s1_go    = s1_valid_reg && advance;
    assign s_tready = !s1_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Accept stage: position counters, border flags, end of image
    // ------------------------------------------------------------------
    logic [AW-1:0] ic_reg, ic_next;
    logic [RW-1:0] ir_reg, ir_next;

    logic          acc_icnz;
    logic          acc_ge1;
    logic          acc_ge2;
    logic          acc_lower;
    logic          acc_emit;
    logic          acc_last;
    logic [CW-1:0] ic_p1;

    always_comb
    begin
        acc_icnz  = (ic_reg != '0);
        acc_ge1   = (ir_reg != '0);
        acc_ge2   = (ir_reg >= RW'(2));
        // Drain beats and rows past the image feed clear pixels
        acc_lower = !s_tuser && (ir_reg < RW'(h_eff)) && s_tdata[0];
        acc_emit  = (acc_icnz && acc_ge1) || acc_ge2;
        // Emitted pixel at or past the last row and column ends the image
        if (acc_icnz)
            acc_last = acc_emit && (CW'(ic_reg) >= CW'(w_eff)) && (ir_reg >= RW'(h_eff));
        else
            acc_last = acc_emit && (ir_reg >= (RW'(h_eff) + RW'(1)));

        ic_p1   = CW'(ic_reg) + CW'(1);
        ic_next = ic_reg;
        ir_next = ir_reg;
        if (acc_last)
        begin
            ic_next = '0;
            ir_next = '0;
        end
        else if (ic_p1 >= CW'(w_eff))
        begin
            ic_next = '0;
            ir_next = ir_reg + RW'(1);
        end
        else
        begin
            ic_next = ic_p1[AW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_reg <= '0;
            ir_reg <= '0;
        end
        else if (s_accept)
        begin
            ic_reg <= ic_next;
            ir_reg <= ir_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: beat waiting for its line store word
    // ------------------------------------------------------------------
    logic              s1_lower_reg;
    logic              s1_ge1_reg;
    logic              s1_ge2_reg;
    logic              s1_icnz_reg;
    logic              s1_emit_reg;
    logic              s1_last_reg;
    logic              s1_fwd_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic [LINE_W-1:0] fwd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Payload of stage 1; forward when the beat in flight writes the same column
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_lower_reg <= acc_lower;
            s1_ge1_reg   <= acc_ge1;
            s1_ge2_reg   <= acc_ge2;
            s1_icnz_reg  <= acc_icnz;
            s1_emit_reg  <= acc_emit;
            s1_last_reg  <= acc_last;
            s1_addr_reg  <= ic_reg;
            s1_fwd_reg   <= s1_go && (s1_addr_reg == ic_reg);
        end
    end

    // ------------------------------------------------------------------
    // Line store: upper and middle rows by column
    // ------------------------------------------------------------------
    logic [LINE_W-1:0] ram_rdata;
    logic [LINE_W-1:0] line_raw;
    logic [LINE_W-1:0] line_wdata;

    assign line_raw   = s1_fwd_reg ? fwd_data_reg : ram_rdata;
    // Shift the column down: middle moves to upper, new pixel to middle
    assign line_wdata = {line_raw[0], s1_lower_reg};

    binc_ram #(
        .DATA_W (LINE_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_go),
        .wr_addr (s1_addr_reg),
        .wr_data (line_wdata),
        .rd_en   (s_accept),
        .rd_addr (ic_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            fwd_data_reg <= line_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Window and neighbor count
    // ------------------------------------------------------------------
    logic [8:0]         win_reg, win_next;
    logic [8:0]         eval_bits;
    logic [2:0]         col_bits;
    logic [COUNT_W-1:0] cnt;
    logic               empty;

    always_comb
    begin
        // Mask rows above the image
        col_bits = {s1_lower_reg, line_raw[0] & s1_ge1_reg, line_raw[1] & s1_ge2_reg};
        if (s1_icnz_reg)
        begin
            win_next  = {col_bits, win_reg[8:3]};
            eval_bits = win_next;
        end
        else
        begin
            // First column: east column lies outside, west columns restart
            eval_bits = {3'b000, win_reg[8:3]};
            win_next  = {col_bits, 6'b000000};
        end
        if (s1_last_reg)
        begin
            win_next = '0;
        end

        empty = !eval_bits[4];
        cnt   = '0;
        if (!empty)
        begin
            cnt = COUNT_W'(eval_bits[1]) + COUNT_W'(eval_bits[3])
                + COUNT_W'(eval_bits[5]) + COUNT_W'(eval_bits[7]);
            if (diag_reg)
            begin
                cnt = cnt + COUNT_W'(eval_bits[0]) + COUNT_W'(eval_bits[2])
                    + COUNT_W'(eval_bits[6]) + COUNT_W'(eval_bits[8]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (s1_go)
        begin
            win_reg <= win_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_empty_reg;
    logic               out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            out_valid_reg <= s1_emit_reg;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit_reg)
        begin
            out_count_reg <= cnt;
            out_empty_reg <= empty;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(STREAM_W - COUNT_W - 1)'(0), out_empty_reg, out_count_reg};
    assign m_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    // End of image returns the position counters to the origin
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && acc_last |=> (ic_reg == '0) && (ir_reg == '0))
        else $error("counters not cleared after last pixel");

    // Row counter never runs past the drain row
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ir_reg <= RW'(H_HI + 1))
        else $error("row counter out of range");

    // Window is clear once the last pixel of an image has been evaluated
    a_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_last_reg |=> (win_reg == '0))
        else $error("window not cleared after last pixel");
`endif

endmodule

// File: design/binc_ram.sv
module binc_ram #(
    parameter int DATA_W = 2,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; hold the last word while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: dv/neighbor_count_checker.sv
`timescale 1ns / 100ps

module neighbor_count_checker
    import binc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [STREAM_W-1:0]  s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [STREAM_W-1:0]  m_tdata,
    input  logic                 m_tlast,
    output int                   mismatch_count,
    output int                   outstanding
);

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               empty;
        logic               last;
    } pixel_result_t;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic             diag_reg;

    logic             upper_row  [BINC_MAX_WIDTH];
    logic             middle_row [BINC_MAX_WIDTH];
    // columns west [2:0], centre [5:3], east [8:6]; in a column: upper, middle, lower
    logic [8:0]       window;
    int unsigned      in_col;
    int unsigned      in_row;
    int               result_index;

    pixel_result_t    expected_results[$];

    task automatic clear_model();
        width_reg  = RST_IMAGE_WIDTH;
        height_reg = RST_IMAGE_HEIGHT;
        diag_reg   = RST_COUNT_DIAGONALS;
        for (int i = 0; i < BINC_MAX_WIDTH; i++)
        begin
            upper_row[i]  = 1'b0;
            middle_row[i] = 1'b0;
        end
        window         = '0;
        in_col         = 0;
        in_row         = 0;
        result_index   = 0;
        mismatch_count = 0;
        expected_results.delete();
    endtask

    function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the 3x3 window by one input beat and queue the pixel it completes.
    task automatic shift_in_pixel(input logic drain, input logic pix);
        int unsigned   w;
        int unsigned   h;
        int unsigned   out_row;
        int unsigned   out_col;
        int            cnt;
        logic          lower;
        logic          up;
        logic          mid;
        logic [8:0]    eval;
        logic          last;
        pixel_result_t r;
        w     = clamp_dim(width_reg, BINC_MAX_WIDTH);
        h     = clamp_dim(height_reg, BINC_MAX_HEIGHT);
        lower = (!drain && in_row < h) ? pix : 1'b0;
        up    = (in_row >= 2) ? upper_row[in_col] : 1'b0;
        mid   = (in_row >= 1) ? middle_row[in_col] : 1'b0;
        upper_row[in_col]  = middle_row[in_col];
        middle_row[in_col] = lower;
        if (in_col >= 1)
        begin
            window = {lower, mid, up, window[8:3]};
            eval   = window;
        end
        else
        begin
            // row wrap: nothing east of the previous pixel, nothing west of this one
            eval   = {3'b000, window[8:3]};
            window = {lower, mid, up, 6'b0};
        end
        last = 1'b0;
        if ((in_col >= 1 && in_row >= 1) || in_row >= 2)
        begin
            out_row = (in_col >= 1) ? in_row - 1 : in_row - 2;
            out_col = (in_col >= 1) ? in_col - 1 : w - 1;
            cnt     = 0;
            r.empty = ~eval[4];
            if (eval[4])
            begin
                cnt = eval[1] + eval[3] + eval[5] + eval[7];
                if (diag_reg)
                    cnt = cnt + eval[0] + eval[2] + eval[6] + eval[8];
            end
            last    = (out_row >= h - 1) && (out_col >= w - 1);
            r.count = COUNT_W'(cnt);
            r.last  = last;
            expected_results.push_back(r);
        end
        if (in_col + 1 >= w)
        begin
            in_col = 0;
            in_row = in_row + 1;
        end
        else
            in_col = in_col + 1;
        if (last)
        begin
            in_col = 0;
            in_row = 0;
            window = '0;
        end
    endtask

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin : watch
        pixel_result_t got;
        pixel_result_t want;
        if (!rst_n)
            clear_model();
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{count: m_tdata[COUNT_W-1:0], empty: m_tdata[COUNT_W], last: m_tlast};
                if (expected_results.size() == 0)
                    note_failure($sformatf("result %0d arrived with none expected: count %0d empty %0b last %0b",
                                           result_index, got.count, got.empty, got.last));
                else
                begin
                    want = expected_results.pop_front();
                    if (got.count !== want.count || got.empty !== want.empty ||
                        got.last !== want.last)
                        note_failure($sformatf(
                            "result %0d: expected count %0d empty %0b last %0b, got count %0d empty %0b last %0b",
                            result_index, want.count, want.empty, want.last,
                            got.count, got.empty, got.last));
                end
                result_index++;
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:     width_reg  = cfg_data;
                    REG_IMAGE_HEIGHT:    height_reg = cfg_data;
                    REG_COUNT_DIAGONALS: diag_reg   = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                shift_in_pixel(s_tuser, s_tdata[0]);
        end
        outstanding = expected_results.size();
    end

endmodule

// File: dv/tb_binary_image_neighbor_counter.sv
`timescale 1ns / 100ps

module tb_binary_image_neighbor_counter;
    import binc_pkg::*;

    // Func codes carried on s_tuser
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // Cycles with no beat on either side before the run is declared hung
    localparam int STALL_LIMIT     = 3000;
    // Long receiver hold-off, long enough to back the block up into its input
    localparam int HOLD_OFF_CYCLES = 400;
    // Quiet cycles after the last result before touching configuration
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_ITEMS    = 350;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [STREAM_W-1:0]  s_tdata;   // [0] pixel, [7:1] zero
    logic                 s_tuser;   // [0] func: 0 pixel, 1 drain
    logic                 m_tvalid;
    logic                 m_tready;
    logic [STREAM_W-1:0]  m_tdata;   // [3:0] neighbor_count, [4] empty_pixel, [7:5] zero
    logic                 m_tlast;   // [0] last_pixel

    int                   mismatch_count;
    int                   outstanding;
    int                   burst_left;
    int                   idle_cycles;
    logic                 hold_off_req;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    binary_image_neighbor_counter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    neighbor_count_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Effective image size after the block's clamp to 1 .. max
    function automatic int clamp_dim(input int v, input int hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Offer one beat and hold it until accepted. Bursts end in a gap with valid
    // low, so valid is never dropped and raised at the same edge.
    task automatic send_beat(input logic func, input logic pix);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(STREAM_W-1){1'b0}}, pix};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write all three registers back to back; only call while the block is idle.
    task automatic configure(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height,
                             input logic diag);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data  <= width;
        @(negedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data  <= height;
        @(negedge clk);
        // upper bits of the flag register are don't-care; toggle them anyway
        cfg_index <= REG_COUNT_DIAGONALS;
        cfg_data  <= {(CFG_W-1)'($urandom_range(0, CFG_MAX >> 1)), diag};
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Drop valid, drain every outstanding result, then let the pipeline settle.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One full image of random content plus its flush. A few drain beats land
    // inside the image and a few pixel beats inside the flush, both read as clear.
    task automatic send_image(input int cols, input int rows, inout int sent);
        int density;
        density = $urandom_range(0, 100);
        for (int i = 0; i < cols * rows; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_beat(FUNC_DRAIN, 1'($urandom_range(0, 1)));
            else
                send_beat(FUNC_PIXEL, $urandom_range(0, 99) < density);
        end
        for (int i = 0; i <= cols; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                send_beat(FUNC_PIXEL, 1'($urandom_range(0, 1)));
            else
                send_beat(FUNC_DRAIN, 1'($urandom_range(0, 1)));
        end
        sent += cols * rows + cols + 1;
    endtask

    // Receiver: cycle through stall patterns; once requested, hold off for a long
    // stretch while the sender keeps pushing so the block fills and backs up.
    initial
    begin : receiver
        int   mode;
        int   span;
        int   tick;
        logic held;
        held     = 1'b0;
        tick     = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req && !held)
            begin
                held = 1'b1;
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (tick % 4) != 0;
                    default: m_tready <= $urandom_range(0, 3) == 0;
                endcase
            end
        end
    end

    // Watchdog: count cycles with no beat accepted on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int random_items;
        int width;
        int height;
        int pick;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_IMAGE_WIDTH;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = FUNC_PIXEL;
        hold_off_req = 1'b0;
        burst_left   = 0;
        random_items = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // 3x4 image, eight neighbours: top three rows all set so the centre
        // sees a full count of 8; the final pixel arrives as a drain beat
        // (reads clear), and the flush mixes in pixel beats past the image.
        configure(CFG_W'(3), CFG_W'(4), 1'b1);
        repeat (11) send_beat(FUNC_PIXEL, 1'b1);
        send_beat(FUNC_DRAIN, 1'b1);
        send_beat(FUNC_PIXEL, 1'b1);
        send_beat(FUNC_DRAIN, 1'b1);
        send_beat(FUNC_DRAIN, 1'b0);
        send_beat(FUNC_PIXEL, 1'b0);
        quiesce();

        // Width zero clamps to a single column; four neighbours only
        configure(CFG_W'(0), CFG_W'(3), 1'b0);
        send_beat(FUNC_PIXEL, 1'b1);
        send_beat(FUNC_PIXEL, 1'b1);
        send_beat(FUNC_PIXEL, 1'b0);
        send_beat(FUNC_DRAIN, 1'b0);
        send_beat(FUNC_DRAIN, 1'b1);
        quiesce();

        // Random phases: mostly small images, a few wider ones, zero sizes included
        while (random_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                width = $urandom_range(0, 8);
            else if (pick < 9)
                width = $urandom_range(9, 48);
            else
                width = $urandom_range(49, 120);
            height = (width <= 8) ? $urandom_range(0, 12) : $urandom_range(0, 3);
            configure(CFG_W'(width), CFG_W'(height), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 3))
                send_image(clamp_dim(width, BINC_MAX_WIDTH),
                           clamp_dim(height, BINC_MAX_HEIGHT), random_items);
            quiesce();
        end

        // Tallest column: an out-of-range height clamps to the row limit; results
        // flow almost at once, so the hold-off backs up the input
        configure(CFG_W'(1), CFG_W'(CFG_MAX), 1'b0);
        hold_off_req = 1'b1;
        send_image(1, BINC_MAX_HEIGHT, random_items);
        quiesce();

        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: filelist.f
design/binc_pkg.sv
design/binc_ram.sv
design/binary_image_neighbor_counter.sv
dv/neighbor_count_checker.sv
dv/tb_binary_image_neighbor_counter.sv
